@@ hdl/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg: shared definitions for the two-stack queue
// Operation codes and the data width used by the queue and its stack memories.
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int DATA_W = 32;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

endpackage

@@ hdl/two_stack_queue.sv @@
// An enqueue that fits gives its result the next cycle, with busy staying low,
// so one enqueue per cycle is taken. A dequeue from a non-empty output stack reads
// the stack from S_IDLE and returns the value from S_PDATA. A transfer moves each entry
// through the input stack's read port (S_XRD), then the output stack's write port (S_XWR).
// Reset (synchronous, rst_n low) empties both stacks; stack contents are not cleared.
// The receiver cannot stall: each result beat is on out_* for exactly one cycle.
// ----------------------------------------------------------------------------
// two_stack_queue: FIFO queue built from two bounded stacks. Enqueue pushes on the
// input stack; dequeue pops the output stack. A dequeue, or an enqueue to a full input
// stack, refills an empty output stack from the input stack one entry per step first.
// ----------------------------------------------------------------------------
module two_stack_queue #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [tsq_pkg::DATA_W-1:0] in_value_in,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [tsq_pkg::DATA_W-1:0] out_value_out
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] ZERO_C  = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XRD,
    S_XWR,
    S_PUSH,
    S_PRD,
    S_PDATA
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               in_cnt_r, in_cnt_nxt;
  logic [CW-1:0]               out_cnt_r, out_cnt_nxt;
  logic                        op_r, op_nxt;
  logic [tsq_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic                        valid_r, valid_nxt;
  logic                        ok_r, ok_nxt;
  logic [tsq_pkg::DATA_W-1:0]  res_r, res_nxt;

  logic                        accept;
  logic [CW-1:0]               in_top, out_top;

  logic                        in_wr_en, in_rd_en, out_wr_en, out_rd_en;
  logic [AW-1:0]               in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
  logic [tsq_pkg::DATA_W-1:0]  in_wr_data, out_wr_data, in_rd_data, out_rd_data;

  assign accept  = start && (state_r == S_IDLE);
  assign in_top  = in_cnt_r - ONE_C;
  assign out_top = out_cnt_r - ONE_C;

  always_comb begin
    state_nxt   = state_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    valid_nxt   = 1'b0;
    ok_nxt      = ok_r;
    res_nxt     = res_r;
    in_wr_en    = 1'b0;
    in_wr_addr  = in_cnt_r[AW-1:0];
    in_wr_data  = val_r;
    in_rd_en    = 1'b0;
    in_rd_addr  = in_top[AW-1:0];
    out_wr_en   = 1'b0;
    out_wr_addr = out_cnt_r[AW-1:0];
    out_wr_data = in_rd_data;
    out_rd_en   = 1'b0;
    out_rd_addr = out_top[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_opcode;
          val_nxt = in_value_in;
          if (in_opcode == tsq_pkg::OP_ENQ) begin
            if (in_cnt_r < DEPTH_C) begin
              in_wr_en   = 1'b1;
              in_wr_data = in_value_in;
              in_cnt_nxt = in_cnt_r + ONE_C;
              valid_nxt  = 1'b1;
              ok_nxt     = 1'b1;
              res_nxt    = '0;
            end else if (out_cnt_r == ZERO_C) begin
              state_nxt = S_XRD;
            end else begin
              valid_nxt = 1'b1;
              ok_nxt    = 1'b0;
              res_nxt   = '0;
            end
          end else begin
            if (out_cnt_r != ZERO_C) begin
              out_rd_en   = 1'b1;
              out_cnt_nxt = out_top;
              state_nxt   = S_PDATA;
            end else if (in_cnt_r != ZERO_C) begin
              state_nxt = S_XRD;
            end else begin
              valid_nxt = 1'b1;
              ok_nxt    = 1'b0;
              res_nxt   = '0;
            end
          end
        end
      end
      S_XRD: begin
        in_rd_en   = 1'b1;
        in_cnt_nxt = in_top;
        state_nxt  = S_XWR;
      end
      S_XWR: begin
        out_wr_en   = 1'b1;
        out_cnt_nxt = out_cnt_r + ONE_C;
        // Stop once the input stack is drained or the output stack fills up.
        if ((in_cnt_r != ZERO_C) && (out_cnt_nxt < DEPTH_C)) begin
          state_nxt = S_XRD;
        end else if (op_r == tsq_pkg::OP_ENQ) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_PUSH: begin
        valid_nxt = 1'b1;
        res_nxt   = '0;
        if (in_cnt_r < DEPTH_C) begin
          in_wr_en   = 1'b1;
          in_cnt_nxt = in_cnt_r + ONE_C;
          ok_nxt     = 1'b1;
        end else begin
          ok_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_PRD: begin
        if (out_cnt_r != ZERO_C) begin
          out_rd_en   = 1'b1;
          out_cnt_nxt = out_top;
          state_nxt   = S_PDATA;
        end else begin
          valid_nxt = 1'b1;
          ok_nxt    = 1'b0;
          res_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_PDATA: begin
        valid_nxt = 1'b1;
        ok_nxt    = 1'b1;
        res_nxt   = out_rd_data;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      valid_r   <= valid_nxt;
    end
    op_r  <= op_nxt;
    val_r <= val_nxt;
    ok_r  <= ok_nxt;
    res_r <= res_nxt;
  end

  tsq_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_in_stack (
    .clk     (clk),
    .wr_en   (in_wr_en),
    .wr_addr (in_wr_addr),
    .wr_data (in_wr_data),
    .rd_en   (in_rd_en),
    .rd_addr (in_rd_addr),
    .rd_data (in_rd_data)
  );

  tsq_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_out_stack (
    .clk     (clk),
    .wr_en   (out_wr_en),
    .wr_addr (out_wr_addr),
    .wr_data (out_wr_data),
    .rd_en   (out_rd_en),
    .rd_addr (out_rd_addr),
    .rd_data (out_rd_data)
  );

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = valid_r;
  assign out_ok        = ok_r;
  assign out_value_out = res_r;

  a_in_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_cnt_r <= DEPTH_C) else $error("input stack count exceeds depth");

  a_out_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= DEPTH_C) else $error("output stack count exceeds depth");

  a_empty_deq_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == tsq_pkg::OP_DEQ) &&
     (in_cnt_r == ZERO_C) && (out_cnt_r == ZERO_C)) |=> (out_valid && !out_ok))
    else $error("dequeue on an empty queue did not fail at once");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_value_out == '0))
    else $error("failed beat carries a nonzero value");

  a_xfer_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XRD) |-> (out_cnt_r < DEPTH_C))
    else $error("transfer started with a full output stack");

endmodule

@@ hdl/tsq_ram.sv @@
// ----------------------------------------------------------------------------
// tsq_ram: stack storage
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [tsq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [tsq_pkg::DATA_W-1:0] rd_data
);

  logic [tsq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [tsq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/tb_two_stack_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_stack_queue: self-checking testbench for the two-stack queue
// Drives enqueue and dequeue commands with random gaps and keeps its own copy
// of both stacks to predict every result beat. Each beat is checked field by
// field. Directed tests cover the empty, full and transfer cases, and random
// bursts then swing the queue between full and empty.
// ----------------------------------------------------------------------------
module tb_two_stack_queue;

  localparam int STACK_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 480;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4 * STACK_DEPTH + 8;

  typedef struct packed {
    logic                              ok;
    logic signed [tsq_pkg::DATA_W-1:0] value;
  } qresult_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_opcode = tsq_pkg::OP_ENQ;
  logic signed [tsq_pkg::DATA_W-1:0] in_value_in = '0;
  logic                              out_valid;
  logic                              out_ok;
  logic signed [tsq_pkg::DATA_W-1:0] out_value_out;

  // Predicted queue contents: the back stack takes new values, the front
  // stack hands out the oldest ones.
  logic signed [tsq_pkg::DATA_W-1:0] back_stack [STACK_DEPTH];
  logic signed [tsq_pkg::DATA_W-1:0] front_stack [STACK_DEPTH];
  int                                back_cnt = 0;
  int                                front_cnt = 0;

  qresult_t pending_results [$];
  int       err_count = 0;
  int       idle_cycles = 0;
  bit       tight_mode = 1'b0;
  int       n_enq = 0;
  int       n_deq = 0;
  int       n_refused = 0;
  int       n_moves = 0;
  int       peak_fill = 0;

  two_stack_queue #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_value_out(out_value_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pop the whole back stack onto the front stack, which reverses the order.
  function automatic void refill_front();
    if (back_cnt > 0) begin
      n_moves++;
    end
    while (back_cnt > 0 && front_cnt < STACK_DEPTH) begin
      back_cnt--;
      front_stack[front_cnt] = back_stack[back_cnt];
      front_cnt++;
    end
  endfunction

  function automatic qresult_t apply_queue_op(
    input logic                              op,
    input logic signed [tsq_pkg::DATA_W-1:0] val
  );
    qresult_t r;
    r.ok    = 1'b0;
    r.value = '0;
    if (op == tsq_pkg::OP_ENQ) begin
      n_enq++;
      if (back_cnt == STACK_DEPTH && front_cnt == 0) begin
        refill_front();
      end
      if (back_cnt < STACK_DEPTH) begin
        back_stack[back_cnt] = val;
        back_cnt++;
        r.ok = 1'b1;
      end
    end else begin
      n_deq++;
      if (front_cnt == 0) begin
        refill_front();
      end
      if (front_cnt > 0) begin
        front_cnt--;
        r.value = front_stack[front_cnt];
        r.ok    = 1'b1;
      end
    end
    if (!r.ok) begin
      n_refused++;
    end
    if (back_cnt + front_cnt > peak_fill) begin
      peak_fill = back_cnt + front_cnt;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    if (tight_mode) begin
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [tsq_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(15, 0))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Called right after a rising edge. Start is only lowered when a gap is
  // wanted, so back-to-back commands keep it high.
  task automatic send_op(input logic op, input logic signed [tsq_pkg::DATA_W-1:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_opcode   <= op;
    in_value_in <= val;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_queue_op(op, val));
  endtask

  // Result beats are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (ok=%0b value=%0d)",
                                  out_ok, out_value_out));
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          report_mismatch($sformatf("ok is %b, expected %b", out_ok, want.ok));
        end
        if (out_value_out !== want.value) begin
          report_mismatch($sformatf("value_out is %0d, expected %0d",
                                    out_value_out, want.value));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty_queue();
    send_op(tsq_pkg::OP_DEQ, 32'sh7fff_ffff);
    send_op(tsq_pkg::OP_DEQ, '0);
  endtask

  // Three entries sit in the back stack, so the first dequeue moves only those.
  task automatic test_partial_transfer();
    send_op(tsq_pkg::OP_ENQ, 32'sh8000_0000);
    send_op(tsq_pkg::OP_ENQ, 32'sh7fff_ffff);
    send_op(tsq_pkg::OP_ENQ, -32'sd1);
    send_op(tsq_pkg::OP_DEQ, rand_value());
  endtask

  // Back stack full while the front stack still holds entries: refused.
  task automatic test_full_refusal();
    send_op(tsq_pkg::OP_ENQ, '0);
    send_op(tsq_pkg::OP_ENQ, 32'sd1);
    send_op(tsq_pkg::OP_ENQ, 32'sh5555_5555);
    send_op(tsq_pkg::OP_ENQ, 32'shaaaa_aaaa);
    repeat (STACK_DEPTH - 4) send_op(tsq_pkg::OP_ENQ, rand_value());
    send_op(tsq_pkg::OP_ENQ, 32'sh1234_5678);
    send_op(tsq_pkg::OP_DEQ, '0);
    send_op(tsq_pkg::OP_DEQ, -32'sd1);
  endtask

  // Back stack full and front stack empty: the enqueue moves all, then pushes.
  task automatic test_full_transfer();
    send_op(tsq_pkg::OP_ENQ, 32'sh0bad_cafe);
    send_op(tsq_pkg::OP_DEQ, '0);
  endtask

  task automatic test_random();
    int issued;
    int burst_len;
    int enq_pct;
    logic op;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(3, 0))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      tight_mode = ($urandom_range(3, 0) == 0);
      repeat (burst_len) begin
        op = ($urandom_range(99, 0) < enq_pct) ? tsq_pkg::OP_ENQ : tsq_pkg::OP_DEQ;
        send_op(op, rand_value());
        issued++;
      end
    end
    tight_mode = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_partial_transfer();
    test_full_refusal();
    test_full_transfer();
    test_random();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d enqueues, %0d dequeues, %0d refused.",
             n_enq + n_deq, n_enq, n_deq, n_refused);
    $display("Stack transfers: %0d, peak occupancy %0d of %0d entries.",
             n_moves, peak_fill, 2 * STACK_DEPTH);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tsq_pkg.sv
hdl/tsq_ram.sv
hdl/two_stack_queue.sv
tb/tb_two_stack_queue.sv
